### src/stp_pkg.sv
// Package: transaction payload types, register indexes and codes for the spanning tree bridge.
package stp_pkg;

    // Fixed field widths of the external payload
    localparam int ID_FIELD_W = 16;
    localparam int COST_W     = 8;
    localparam int PORT_W     = 3;
    localparam int MAX_PORTS  = 8;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 1;

    localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_ID   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ATTACHED = 1'b1;

    // Input transaction kinds
    localparam logic KIND_RECEIVE = 1'b0;
    localparam logic KIND_EMIT    = 1'b1;

    typedef enum logic [1:0] {
        ROLE_DESIGNATED = 2'd0,
        ROLE_ROOT       = 2'd1,
        ROLE_BLOCKED    = 2'd2,
        ROLE_ABSENT     = 2'd3
    } role_t;

    typedef struct packed {
        logic                  kind;
        logic [PORT_W-1:0]     rx_port;
        logic [ID_FIELD_W-1:0] msg_root_id;
        logic [COST_W-1:0]     msg_cost;
        logic [ID_FIELD_W-1:0] msg_sender_id;
    } in_item_t;

    typedef struct packed {
        logic [PORT_W-1:0]     out_port;
        role_t                 role;
        logic [ID_FIELD_W-1:0] tx_root_id;
        logic [COST_W-1:0]     tx_cost;
        logic [ID_FIELD_W-1:0] tx_sender_id;
        logic                  last;
    } out_item_t;

endpackage

### src/stp_bridge_port_roles_top.sv
// Spanning tree bridge: per-port best message store, root election and port role report.
//
// One bridge of a simplified spanning tree election. A receive transaction
// (kind 0) is taken and then passes through ST_RX_PORT and ST_RX_BEST, in which
// one shared message comparator checks it first against the best message held
// for its port and then against the bridge's own best; a message on a port that
// is not attached (or not below NUM_PORTS) is dropped at once. An emit
// transaction (kind 1) yields min(NUM_PORTS, 8) results, one port per cycle
// while the output is not stalled, through the same comparator, so it keeps the
// input stalled until the final port is reported; last marks the final port. No
// new transaction is taken until the current one is finished. Messages order by
// root id, cost, sender id, then port, lower winning; ids use their low ID_BITS
// bits and the bridge's own cost saturates at 255. Writing the bridge's own id
// restarts the election; writing attached_ports forgets the stored message of
// every port whose bit is cleared.
module stp_bridge_port_roles_top #(
    parameter int NUM_PORTS = 8,
    parameter int ID_BITS   = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  stp_pkg::in_item_t                  in_data,
    output logic                               out_valid,
    input  logic                               out_stall,
    output stp_pkg::out_item_t                 out_data,
    input  logic                               cfg_we,
    input  logic [stp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [stp_pkg::CFG_W-1:0]          cfg_data
);

    localparam int SLOTS  = (NUM_PORTS < stp_pkg::MAX_PORTS) ? NUM_PORTS : stp_pkg::MAX_PORTS;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int PORT_W = stp_pkg::PORT_W;
    localparam int COST_W = stp_pkg::COST_W;
    localparam int KEY_W  = 2 * ID_BITS + COST_W + PORT_W;

    localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(SLOTS - 1);
    localparam logic [PORT_W:0]   SLOTS_L  = (PORT_W + 1)'(SLOTS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RX_PORT,
        ST_RX_BEST,
        ST_EMIT
    } state_t;

    typedef logic [KEY_W-1:0] key_t;

    state_t                      state_reg, state_next;
    logic [ID_BITS-1:0]          self_id_reg, self_id_next;
    logic [stp_pkg::MAX_PORTS-1:0] attached_reg, attached_next;
    key_t                        best_reg, best_next;
    logic [COST_W-1:0]           own_cost_reg, own_cost_next;
    logic                        root_valid_reg, root_valid_next;
    key_t                        slot_key_reg [SLOTS];
    key_t                        slot_key_next [SLOTS];
    logic [SLOTS-1:0]            slot_valid_reg, slot_valid_next;
    key_t                        msg_reg, msg_next;
    logic [SLOT_W-1:0]           idx_reg, idx_next;
    logic                        out_valid_reg, out_valid_next;
    stp_pkg::out_item_t          out_data_reg, out_data_next;

    // Shared comparator and slot read
    key_t                        cmp_a, cmp_b;
    logic                        cmp_lt;
    key_t                        rd_key;
    logic                        rd_valid;
    key_t                        own_key;
    key_t                        in_key;
    logic [PORT_W-1:0]           idx_port;
    logic                        rx_ok;
    logic                        out_free;
    logic                        desig;
    logic [COST_W-1:0]           msg_cost;

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    assign rd_key   = slot_key_reg[idx_reg];
    assign rd_valid = slot_valid_reg[idx_reg];
    assign idx_port = PORT_W'(idx_reg);
    assign own_key  = {best_reg[KEY_W-1 -: ID_BITS], own_cost_reg, self_id_reg, idx_port};
    assign in_key   = {ID_BITS'(in_data.msg_root_id), in_data.msg_cost,
                       ID_BITS'(in_data.msg_sender_id), in_data.rx_port};
    assign rx_ok    = ({1'b0, in_data.rx_port} < SLOTS_L) && attached_reg[in_data.rx_port];
    assign msg_cost = msg_reg[PORT_W + ID_BITS +: COST_W];

    // Operand select for the one comparator
    always_comb
    begin
        cmp_a = msg_reg;
        cmp_b = rd_key;
        case (state_reg)
            ST_RX_BEST:
            begin
                cmp_b = best_reg;
            end
            ST_EMIT:
            begin
                cmp_a = own_key;
            end
            default:
            begin
                cmp_b = rd_key;
            end
        endcase
    end

    assign cmp_lt = cmp_a < cmp_b;
    assign desig  = attached_reg[idx_port] && (!rd_valid || cmp_lt);

    // Sequencer and next-state logic
    always_comb
    begin
        state_next      = state_reg;
        self_id_next    = self_id_reg;
        attached_next   = attached_reg;
        best_next       = best_reg;
        own_cost_next   = own_cost_reg;
        root_valid_next = root_valid_reg;
        slot_key_next   = slot_key_reg;
        slot_valid_next = slot_valid_reg;
        msg_next        = msg_reg;
        idx_next        = idx_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_data_next   = out_data_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_data.kind == stp_pkg::KIND_EMIT)
                    begin
                        idx_next   = '0;
                        state_next = ST_EMIT;
                    end
                    else if (rx_ok)
                    begin
                        msg_next   = in_key;
                        idx_next   = in_data.rx_port[SLOT_W-1:0];
                        state_next = ST_RX_PORT;
                    end
                end
            end
            ST_RX_PORT:
            begin
                // keep the better of stored and new message for this port
                if (!rd_valid || cmp_lt)
                begin
                    slot_key_next[idx_reg]   = msg_reg;
                    slot_valid_next[idx_reg] = 1'b1;
                end
                state_next = ST_RX_BEST;
            end
            ST_RX_BEST:
            begin
                // adopt message as own best: new root, root port and cost
                if (cmp_lt)
                begin
                    best_next       = msg_reg;
                    own_cost_next   = (msg_cost == stp_pkg::COST_MAX) ? msg_cost
                                                                      : msg_cost + 1'b1;
                    root_valid_next = 1'b1;
                end
                state_next = ST_IDLE;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next         = 1'b1;
                    out_data_next.out_port = idx_port;
                    out_data_next.last     = (idx_reg == LAST_IDX);
                    if (!attached_reg[idx_port])
                        out_data_next.role = stp_pkg::ROLE_ABSENT;
                    else if (desig)
                        out_data_next.role = stp_pkg::ROLE_DESIGNATED;
                    else if (root_valid_reg && (best_reg[PORT_W-1:0] == idx_port))
                        out_data_next.role = stp_pkg::ROLE_ROOT;
                    else
                        out_data_next.role = stp_pkg::ROLE_BLOCKED;
                    out_data_next.tx_root_id   = desig ?
                        stp_pkg::ID_FIELD_W'(best_reg[KEY_W-1 -: ID_BITS]) : '0;
                    out_data_next.tx_cost      = desig ? own_cost_reg : '0;
                    out_data_next.tx_sender_id = desig ?
                        stp_pkg::ID_FIELD_W'(self_id_reg) : '0;
                    if (idx_reg == LAST_IDX)
                        state_next = ST_IDLE;
                    else
                        idx_next = idx_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Configuration writes (to be issued only while idle; the block itself does not enforce this)
        if (cfg_we)
        begin
            case (cfg_index)
                stp_pkg::CFG_OWN_ID:
                begin
                    self_id_next    = ID_BITS'(cfg_data);
                    best_next       = {ID_BITS'(cfg_data), {(KEY_W - ID_BITS){1'b0}}};
                    own_cost_next   = '0;
                    root_valid_next = 1'b0;
                    slot_valid_next = '0;
                end
                stp_pkg::CFG_ATTACHED:
                begin
                    attached_next = cfg_data[stp_pkg::MAX_PORTS-1:0];
                    for (int p = 0; p < SLOTS; p++)
                    begin
                        if (!cfg_data[p])
                            slot_valid_next[p] = 1'b0;
                    end
                end
                default:
                begin
                    attached_next = attached_reg;
                end
            endcase
        end
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            self_id_reg    <= ID_BITS'(1);
            attached_reg   <= '0;
            best_reg       <= {ID_BITS'(1), {(KEY_W - ID_BITS){1'b0}}};
            own_cost_reg   <= '0;
            root_valid_reg <= 1'b0;
            for (int s = 0; s < SLOTS; s++)
            begin
                slot_key_reg[s] <= '0;
            end
            slot_valid_reg <= '0;
            msg_reg        <= '0;
            idx_reg        <= '0;
            out_valid_reg  <= 1'b0;
            out_data_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            self_id_reg    <= self_id_next;
            attached_reg   <= attached_next;
            best_reg       <= best_next;
            own_cost_reg   <= own_cost_next;
            root_valid_reg <= root_valid_next;
            slot_key_reg   <= slot_key_next;
            slot_valid_reg <= slot_valid_next;
            msg_reg        <= msg_next;
            idx_reg        <= idx_next;
            out_valid_reg  <= out_valid_next;
            out_data_reg   <= out_data_next;
        end
    end

`ifndef SYNTHESIS
    // A result appears only while walking the ports
    a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_EMIT))
        else $error("result raised outside emit walk");

    // The known root never exceeds this bridge's id
    a_root_not_worse: assert property (@(posedge clk) disable iff (!rst_n)
        best_reg[KEY_W-1 -: ID_BITS] <= self_id_reg)
        else $error("known root worse than own id");

    // Without a root port the bridge is root with zero cost
    a_cost_when_root: assert property (@(posedge clk) disable iff (!rst_n)
        !root_valid_reg |-> (own_cost_reg == '0))
        else $error("nonzero cost while bridge is root");

    // Reported ports stay inside the walked range
    a_port_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ({1'b0, out_data_reg.out_port} < SLOTS_L))
        else $error("result port out of range");
`endif

endmodule

### verif/tb_stp_bridge_port_roles_top.sv
// Testbench for the spanning tree bridge: role prediction, scoreboard, paced stimulus.
module tb_stp_bridge_port_roles_top;

    localparam int DRAIN_CYCLES = 8;
    localparam int LIMIT_TIME   = 500000;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 25;

    // Configuration message; field order gives the election order as a plain compare
    typedef struct packed {
        logic [stp_pkg::ID_FIELD_W-1:0] root;
        logic [stp_pkg::COST_W-1:0]     cost;
        logic [stp_pkg::ID_FIELD_W-1:0] sender;
        logic [stp_pkg::PORT_W-1:0]     port;
    } bpdu_t;

    // Election state of one bridge plus the queue of port reports still owed
    class role_tracker;
        logic [stp_pkg::ID_FIELD_W-1:0] self_id;
        logic [stp_pkg::MAX_PORTS-1:0]  attached;
        logic [stp_pkg::ID_FIELD_W-1:0] known_root;
        logic [stp_pkg::COST_W-1:0]     own_cost;
        bit                             root_port_ok;
        logic [stp_pkg::PORT_W-1:0]     root_port;
        bit                             self_best;
        bpdu_t                          best_msg;
        bit                             port_held [stp_pkg::MAX_PORTS];
        bpdu_t                          port_best [stp_pkg::MAX_PORTS];
        stp_pkg::out_item_t             pending_reports [$];
        int                             errors;
        int                             checked;
        int                             n_rx;
        int                             n_ignored;
        int                             n_emit;

        function new();
            self_id  = 16'd1;
            attached = '0;
            restart_election();
        endfunction

        function void restart_election();
            known_root   = self_id;
            own_cost     = '0;
            root_port_ok = 1'b0;
            root_port    = '0;
            self_best    = 1'b1;
            best_msg     = '0;
            best_msg.root = self_id;
            foreach (port_held[p])
                port_held[p] = 1'b0;
        endfunction

        function void write_reg(logic [stp_pkg::CFG_IDX_W-1:0] idx,
                                logic [stp_pkg::CFG_W-1:0] value);
            if (idx == stp_pkg::CFG_OWN_ID)
            begin
                self_id = value;
                restart_election();
            end
            else
            begin
                attached = value[stp_pkg::MAX_PORTS-1:0];
                foreach (port_held[p])
                    if (!attached[p])
                        port_held[p] = 1'b0;
            end
        endfunction

        function int outstanding();
            return pending_reports.size();
        endfunction

        // Accepted input transaction: update election state or queue port reports
        function void note_item(stp_pkg::in_item_t it);
            bpdu_t              m;
            bpdu_t              own;
            bit                 wins;
            bit                 desig;
            stp_pkg::out_item_t r;
            if (it.kind == stp_pkg::KIND_RECEIVE)
            begin
                n_rx++;
                if (!attached[it.rx_port])
                begin
                    n_ignored++;
                    return;
                end
                m.root   = it.msg_root_id;
                m.cost   = it.msg_cost;
                m.sender = it.msg_sender_id;
                m.port   = it.rx_port;
                if (!port_held[m.port] || m < port_best[m.port])
                begin
                    port_held[m.port] = 1'b1;
                    port_best[m.port] = m;
                end
                // while the bridge still sees itself as root only the root id counts
                wins = self_best ? (m.root < best_msg.root) : (m < best_msg);
                if (wins)
                begin
                    self_best    = 1'b0;
                    best_msg     = m;
                    known_root   = m.root;
                    own_cost     = (m.cost == stp_pkg::COST_MAX) ? stp_pkg::COST_MAX
                                                                 : m.cost + 1'b1;
                    root_port_ok = 1'b1;
                    root_port    = m.port;
                end
            end
            else
            begin
                n_emit++;
                for (int p = 0; p < stp_pkg::MAX_PORTS; p++)
                begin
                    r = '0;
                    r.out_port = p[stp_pkg::PORT_W-1:0];
                    r.last     = (p == stp_pkg::MAX_PORTS - 1);
                    desig      = 1'b0;
                    if (!attached[p])
                        r.role = stp_pkg::ROLE_ABSENT;
                    else
                    begin
                        own.root   = known_root;
                        own.cost   = own_cost;
                        own.sender = self_id;
                        own.port   = p[stp_pkg::PORT_W-1:0];
                        desig = !port_held[p] || own < port_best[p];
                        if (desig)
                            r.role = stp_pkg::ROLE_DESIGNATED;
                        else if (root_port_ok && root_port == p[stp_pkg::PORT_W-1:0])
                            r.role = stp_pkg::ROLE_ROOT;
                        else
                            r.role = stp_pkg::ROLE_BLOCKED;
                    end
                    if (desig)
                    begin
                        r.tx_root_id   = known_root;
                        r.tx_cost      = own_cost;
                        r.tx_sender_id = self_id;
                    end
                    pending_reports = {pending_reports, r};
                end
            end
        endfunction

        function void compare_field(string what, logic [15:0] want, logic [15:0] seen);
            if (want !== seen)
            begin
                errors++;
                if (errors <= 20)
                    $display("%0t: %s mismatch, expected %0h, actual %0h",
                             $time, what, want, seen);
            end
        endfunction

        // Accepted output transaction: compare with the oldest owed report
        function void check_report(stp_pkg::out_item_t got);
            stp_pkg::out_item_t want;
            if (pending_reports.size() == 0)
            begin
                errors++;
                if (errors <= 20)
                    $display("%0t: unexpected report, expected none, actual %h",
                             $time, got);
                return;
            end
            want = pending_reports.pop_front();
            checked++;
            compare_field("out_port", 16'(want.out_port), 16'(got.out_port));
            compare_field("role", 16'(want.role), 16'(got.role));
            compare_field("tx_root_id", want.tx_root_id, got.tx_root_id);
            compare_field("tx_cost", 16'(want.tx_cost), 16'(got.tx_cost));
            compare_field("tx_sender_id", want.tx_sender_id, got.tx_sender_id);
            compare_field("last", 16'(want.last), 16'(got.last));
        endfunction
    endclass

    logic                          clk;
    logic                          rst_n     = 1'b0;
    logic                          in_valid  = 1'b0;
    logic                          in_stall;
    stp_pkg::in_item_t             in_data   = '0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    stp_pkg::out_item_t            out_data;
    logic                          cfg_we    = 1'b0;
    logic [stp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [stp_pkg::CFG_W-1:0]     cfg_data  = '0;

    role_tracker                    trk = new();
    logic [8:0]                     stall_tick = '0;
    logic [stp_pkg::ID_FIELD_W-1:0] id_window;
    int                             burst_left = 0;
    int                             n_cfg = 0;

    stp_bridge_port_roles_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #(LIMIT_TIME);
        $display("Timeout at %0t", $time);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Monitors: accepted transactions on both channels
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            trk.note_item(in_data);
        if (rst_n && out_valid && !out_stall)
            trk.check_report(out_data);
    end

    // Receiver back-pressure: free, random, periodic and heavy stretches
    always @(posedge clk)
    begin
        stall_tick <= stall_tick + 1'b1;
        case (stall_tick[8:7])
            2'd0:    out_stall <= 1'b0;
            2'd1:    out_stall <= ($urandom_range(0, 2) == 0);
            2'd2:    out_stall <= (stall_tick[2:0] >= 3'd5);
            default: out_stall <= ($urandom_range(0, 1) == 0);
        endcase
    end

    // Present one transaction and hold it until accepted
    task automatic send_item(input stp_pkg::in_item_t it);
        in_valid <= 1'b1;
        in_data  <= it;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Sender bursts with random gaps in between
    task automatic pace();
        int gap;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Wait until every owed report is back and a receive has settled
    task automatic drain();
        in_valid <= 1'b0;
        // wait for the clock so the monitor has noted the last accepted transaction
        @(posedge clk);
        while (trk.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_regs(input bit set_id, input logic [15:0] id_val,
                              input bit set_att, input logic [7:0] att_val);
        drain();
        if (set_id)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= stp_pkg::CFG_OWN_ID;
            cfg_data  <= id_val;
            @(posedge clk);
            trk.write_reg(stp_pkg::CFG_OWN_ID, id_val);
            n_cfg++;
        end
        if (set_att)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= stp_pkg::CFG_ATTACHED;
            cfg_data  <= {8'h00, att_val};
            @(posedge clk);
            trk.write_reg(stp_pkg::CFG_ATTACHED, {8'h00, att_val});
            n_cfg++;
        end
        cfg_we <= 1'b0;
    endtask

    function automatic stp_pkg::in_item_t make_msg(int port, logic [15:0] root,
                                                   logic [7:0] cost, logic [15:0] sender);
        stp_pkg::in_item_t it;
        it.kind          = stp_pkg::KIND_RECEIVE;
        it.rx_port       = stp_pkg::PORT_W'(port);
        it.msg_root_id   = root;
        it.msg_cost      = cost;
        it.msg_sender_id = sender;
        return it;
    endfunction

    function automatic stp_pkg::in_item_t emit_item();
        stp_pkg::in_item_t it;
        logic [63:0]       raw;
        raw     = {$urandom, $urandom};
        it      = raw[$bits(stp_pkg::in_item_t)-1:0];
        it.kind = stp_pkg::KIND_EMIT;
        return it;
    endfunction

    // Messages mostly near the bridge id so elections go both ways
    function automatic stp_pkg::in_item_t random_item();
        stp_pkg::in_item_t it;
        int                pick;
        if ($urandom_range(0, 9) < 3)
            return emit_item();
        it = make_msg($urandom_range(0, 7), 16'($urandom), 8'($urandom), 16'($urandom));
        if ($urandom_range(0, 9) < 6)
            it.msg_root_id = id_window + 16'($urandom_range(0, 4));
        pick = $urandom_range(0, 9);
        if (pick < 5)
            it.msg_cost = 8'($urandom_range(0, 3));
        else if (pick < 7)
            it.msg_cost = 8'($urandom_range(253, 255));
        if ($urandom_range(0, 1) == 0)
            it.msg_sender_id = id_window + 16'($urandom_range(0, 3));
        return it;
    endfunction

    initial
    begin
        stp_pkg::in_item_t it;
        int                counted;
        logic [15:0]       id_val;
        logic [7:0]        att_val;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset state: no port attached, a receive is dropped
        send_item(emit_item());
        send_item(make_msg(3, 16'h0000, 8'h00, 16'h0000));
        pace();

        // Full attachment: root takeover, cost saturation, blocked and tie on port
        write_regs(1'b1, 16'h0010, 1'b1, 8'hFF);
        send_item(emit_item());
        send_item(make_msg(0, 16'h0005, 8'h03, 16'h0007));
        send_item(make_msg(1, 16'hFFFF, 8'hFF, 16'hFFFF));
        pace();
        send_item(make_msg(2, 16'h0000, 8'hFF, 16'h0000));
        send_item(emit_item());
        send_item(make_msg(4, 16'h0000, 8'd100, 16'h0009));
        pace();
        send_item(make_msg(5, 16'h0000, 8'd100, 16'h000A));
        send_item(make_msg(6, 16'h0000, 8'd100, 16'h0009));
        send_item(emit_item());
        pace();

        // Detach all but the root port: root role with no designated port
        write_regs(1'b0, 16'h0000, 1'b1, 8'h10);
        send_item(emit_item());
        send_item(make_msg(7, 16'h0000, 8'h00, 16'h0000));
        send_item(emit_item());

        // Lowest bridge id: an equal message leaves the port blocked
        write_regs(1'b1, 16'h0000, 1'b0, 8'h00);
        send_item(make_msg(4, 16'h0000, 8'h00, 16'h0000));
        send_item(emit_item());
        pace();

        // Highest bridge id: successive takeovers decided by sender id
        write_regs(1'b1, 16'hFFFF, 1'b1, 8'hFF);
        send_item(make_msg(7, 16'hFFFE, 8'h00, 16'hFFFF));
        send_item(make_msg(3, 16'hFFFE, 8'h00, 16'h0000));
        send_item(emit_item());
        pace();

        // Random phases, each under its own configuration
        for (int phase = 0; phase < PHASES; phase++)
        begin
            if (phase == 0)
                id_val = 16'h0000;
            else if (phase == 1)
                id_val = 16'hFFFF;
            else
                id_val = 16'($urandom);
            if (phase < 2)
                att_val = 8'hFF;
            else if (phase == PHASES - 1)
                att_val = 8'h80;
            else
                att_val = 8'($urandom | $urandom);
            write_regs(phase < 2 || $urandom_range(0, 1) == 0, id_val,
                       phase < 2 || phase == PHASES - 1 || $urandom_range(0, 3) != 0,
                       att_val);
            id_window = trk.self_id - 16'd2;
            counted = 0;
            while (counted < PHASE_ITEMS)
            begin
                it = random_item();
                if (it.kind == stp_pkg::KIND_EMIT || trk.attached[it.rx_port])
                    counted++;
                send_item(it);
                pace();
            end
        end

        drain();
        $display("Covered %0d messages (%0d dropped) and %0d emits, %0d port reports checked,",
                 trk.n_rx, trk.n_ignored, trk.n_emit, trk.checked);
        $display("under %0d register writes including lowest and highest bridge ids.", n_cfg);
        if (trk.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### filelist.f
src/stp_pkg.sv
src/stp_bridge_port_roles_top.sv
verif/tb_stp_bridge_port_roles_top.sv
